@@ rtl/sbh_pkg.sv @@
// Shared types, constants and tables for the SHA-256 byte stream hasher.
package sbh_pkg;

  // Byte position where the 64-bit length field starts in the last block
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [7:0] PadByte = 8'h80;

  // Initial hash values
  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Source of the byte pushed into the block buffer
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } push_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      push;       // shift one byte into the block buffer
    push_sel_e sel;        // which byte
    logic      count;      // message byte: bump the byte count
    logic      round;      // run one compression round
    logic [5:0] round_idx; // round number
    logic      hash_add;   // fold working variables into the hash
    logic      reinit;     // return to the initial state for a new message
    logic [2:0] idx;       // length byte or digest word index
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [5:0] fill;      // bytes held in the current block
  } sts_t;

endpackage

@@ rtl/sha256_byte_stream_hasher.sv @@
// Top level of the SHA-256 byte stream hasher.
//
// Input channel (in_valid_i/in_ready_o): one item per transfer. mode_i = 0
// appends data_byte_i to the message; mode_i = 1 finishes the message.
// Output channel (out_valid_o/out_ready_i): after a finish, eight transfers
// carry the digest words, word_index_o 0 (most significant) first, with
// last_word_o set on word 7.
// The 64th appended byte of a block starts the compression, one round per cycle
// on a single round unit, then a fold into the hash, with the input not ready.
// A finish pushes the 0x80 byte, zero bytes and eight length bytes through the
// block buffer, at most one per cycle, then compresses; if the padding spills
// into a second block, the first is compressed before the rest is pushed. The
// eight digest words follow, one per cycle at best.
// Reset: hash words take their initial values and the byte and fill counts
// clear; the block is ready at once. A stalled receiver holds the current
// word on the output and no input is taken until the last word has gone,
// after which the block is set up for the next message.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sbh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  sbh_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_word_o (digest_word_o)
  );

endmodule

@@ rtl/sbh_dp.sv @@
// Datapath: block buffer and message schedule, round logic, hash words, counts.
module sbh_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     data_byte_i,
  input  sbh_pkg::cmd_t  cmd_i,
  output sbh_pkg::sts_t  sts_o,
  output logic [31:0]    digest_word_o
);
  import sbh_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  logic [511:0] buf_q, buf_d;
  logic [31:0]  hash_q [8];
  logic [31:0]  hash_d [8];
  logic [31:0]  work_q [8];
  logic [31:0]  work_d [8];
  logic [31:0]  rin [8];
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  bcnt_q, bcnt_d;
  logic [63:0]  bits;
  logic [7:0]   push_byte;
  logic [31:0]  w0, w1, w9, w14, wnew;
  logic [31:0]  sg0, sg1, big0, big1, chs, maj, t1, t2;

  // Byte to push
  assign bits = {bcnt_q[60:0], 3'b000};
  always_comb begin
    unique case (cmd_i.sel)
      SEL_DATA: push_byte = data_byte_i;
      SEL_PAD:  push_byte = PadByte;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = bits[{~cmd_i.idx, 3'b000} +: 8];
      default:  push_byte = 8'h00;
    endcase
  end

  // Schedule window: word 0 is the oldest, W[t] during round t
  assign w0   = buf_q[511:480];
  assign w1   = buf_q[479:448];
  assign w9   = buf_q[223:192];
  assign w14  = buf_q[63:32];
  assign sg0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign sg1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign wnew = w0 + sg0 + w9 + sg1;

  // One compression round; round 0 starts from the hash words
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rin[i] = (cmd_i.round_idx == 6'd0) ? hash_q[i] : work_q[i];
    end
    big1 = rotr(rin[4], 6) ^ rotr(rin[4], 11) ^ rotr(rin[4], 25);
    chs  = (rin[4] & rin[5]) ^ (~rin[4] & rin[6]);
    t1   = rin[7] + big1 + chs + RoundK[cmd_i.round_idx] + w0;
    big0 = rotr(rin[0], 2) ^ rotr(rin[0], 13) ^ rotr(rin[0], 22);
    maj  = (rin[0] & rin[1]) ^ (rin[0] & rin[2]) ^ (rin[1] & rin[2]);
    t2   = big0 + maj;
    work_d[0] = t1 + t2;
    work_d[1] = rin[0];
    work_d[2] = rin[1];
    work_d[3] = rin[2];
    work_d[4] = rin[3] + t1;
    work_d[5] = rin[4];
    work_d[6] = rin[5];
    work_d[7] = rin[6];
  end

  // Next values of buffer, hash and counts
  always_comb begin
    buf_d  = buf_q;
    fill_d = fill_q;
    bcnt_d = bcnt_q;
    for (int i = 0; i < 8; i++) begin
      hash_d[i] = hash_q[i];
    end
    if (cmd_i.push) begin
      buf_d  = {buf_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
    end else if (cmd_i.round) begin
      buf_d = {buf_q[479:0], wnew};
    end
    if (cmd_i.count) begin
      bcnt_d = bcnt_q + 64'd1;
    end
    if (cmd_i.hash_add) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + work_q[i];
      end
    end
    if (cmd_i.reinit) begin
      fill_d = '0;
      bcnt_d = '0;
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = HashInit[i];
      end
    end
  end

  // Control-relevant registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bcnt_q <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= HashInit[i];
      end
    end else begin
      fill_q <= fill_d;
      bcnt_q <= bcnt_d;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_d[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (cmd_i.round) begin
      for (int i = 0; i < 8; i++) begin
        work_q[i] <= work_d[i];
      end
    end
  end

  assign sts_o.fill    = fill_q;
  assign digest_word_o = hash_q[cmd_i.idx];

endmodule

@@ rtl/sbh_ctrl.sv @@
// Controller: sequences byte pushes, padding, compression rounds and digest output.
module sbh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           mode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     word_index_o,
  output logic           last_word_o,
  input  sbh_pkg::sts_t  sts_i,
  output sbh_pkg::cmd_t  cmd_o
);
  import sbh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ZERO,
    S_LEN,
    S_COMP,
    S_ADD,
    S_OUT
  } state_e;

  state_e     state_q, state_d, ret_q, ret_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       full;

  assign full = (sts_i.fill == 6'd63);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.sel       = SEL_DATA;
    cmd_o.round_idx = rnd_q;
    cmd_o.idx       = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i) begin
            cmd_o.push  = 1'b1;
            cmd_o.count = 1'b1;
            if (full) begin
              state_d = S_COMP;
              ret_d   = S_IDLE;
            end
          end else begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = SEL_PAD;
        state_d    = full ? S_COMP : S_ZERO;
        ret_d      = S_ZERO;
      end
      S_ZERO: begin
        if (sts_i.fill == LenPos) begin
          state_d = S_LEN;
          idx_d   = '0;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = SEL_ZERO;
          if (full) begin
            state_d = S_COMP;
            ret_d   = S_ZERO;
          end
        end
      end
      S_LEN: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = SEL_LEN;
        idx_d      = idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          state_d = S_COMP;
          ret_d   = S_OUT;
        end
      end
      S_COMP: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.hash_add = 1'b1;
        state_d        = ret_q;
      end
      S_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.reinit = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 3'd7);

`ifndef SYNTHESIS
  // Input and output sides never open together
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest is being shown");

  // A byte that fills the block starts compression
  a_full_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !mode_i && full) |=> (state_q == S_COMP && rnd_q == 6'd0))
    else $error("full block did not start compression");

  // Rounds run only in the compression state
  a_round_ctr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_COMP) |-> (rnd_q == 6'd0))
    else $error("round counter left nonzero outside compression");

  // After the last digest word the block is ready for a new message
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (in_ready_o && sts_i.fill == 6'd0))
    else $error("no return to idle after the last digest word");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the SHA-256 byte stream hasher.
module testbench;

  // Input item operations
  typedef enum bit {
    OP_APPEND = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  // One expected digest transfer
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam logic [7:0]  PAD_MARK      = 8'h80;
  localparam int unsigned LEN_FIELD_POS = 56;

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        mode_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // Predictor state
  logic [31:0] hash_st [8];
  logic [7:0]  msg_blk [64];
  int unsigned blk_fill;
  logic [63:0] msg_bytes;

  digest_word_t digest_q [$];

  int unsigned fail_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned items_sent = 0;
  bit          quiet      = 1'b0;
  bit          hold_req   = 1'b0;
  bit          hold_ack   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  sha256_byte_stream_hasher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hash predictor
  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) hash_st[i] = SHA_H0[i];
    for (int i = 0; i < 64; i++) msg_blk[i] = 8'h00;
    blk_fill = 0;
    msg_bytes = '0;
  endfunction

  function automatic void hash_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_blk[4*i], msg_blk[4*i+1], msg_blk[4*i+2], msg_blk[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endfunction

  // Advance the predictor by one accepted item; a finish queues the digest
  function automatic void hash_step(op_e op, logic [7:0] b);
    logic [63:0]  nbits;
    int unsigned  pos;
    digest_word_t dw;
    if (op == OP_APPEND) begin
      msg_blk[blk_fill] = b;
      msg_bytes++;
      blk_fill++;
      if (blk_fill == 64) begin
        hash_compress();
        blk_fill = 0;
      end
    end else begin
      nbits = msg_bytes << 3;
      pos = blk_fill;
      msg_blk[pos] = PAD_MARK;
      pos++;
      // no room for the length: pad out this block and start another
      if (pos > LEN_FIELD_POS) begin
        while (pos < 64) begin
          msg_blk[pos] = 8'h00;
          pos++;
        end
        hash_compress();
        pos = 0;
      end
      while (pos < LEN_FIELD_POS) begin
        msg_blk[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) msg_blk[LEN_FIELD_POS + i] = nbits[63 - 8*i -: 8];
      hash_compress();
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_st[i];
        dw.idx  = 3'(i);
        dw.last = (i == 7);
        digest_q = {digest_q, dw};
      end
      hash_restart();
    end
  endfunction

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Digest checker
  always @(posedge clk_i) begin
    digest_word_t dw;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        $error("digest transfer with nothing expected: word %h index %0d",
               digest_word_o, word_index_o);
        fail_cnt++;
      end else begin
        dw = digest_q.pop_front();
        if (digest_word_o !== dw.word) begin
          $error("digest_word: expected %h, actual %h", dw.word, digest_word_o);
          fail_cnt++;
        end
        if (word_index_o !== dw.idx) begin
          $error("word_index: expected %0d, actual %0d", dw.idx, word_index_o);
          fail_cnt++;
        end
        if (last_word_o !== dw.last) begin
          $error("last_word: expected %0b, actual %0b", dw.last, last_word_o);
          fail_cnt++;
        end
      end
    end
  end

  // Offer one item, with an optional idle burst first, and wait for the transfer
  task automatic send_item(op_e op, logic [7:0] b);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= op;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    hash_step(op, b);
    items_sent++;
  endtask

  task automatic send_random_bytes(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(OP_APPEND, 8'($urandom));
  endtask

  // Drop valid and wait for every queued digest word
  task automatic wait_digests_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // empty message, then a second finish right after
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'hff);
    // "abc"
    send_item(OP_APPEND, 8'h61);
    send_item(OP_APPEND, 8'h62);
    send_item(OP_APPEND, 8'h63);
    send_item(OP_FINISH, 8'h5a);
    // extreme byte values
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, 8'hff);
    send_item(OP_APPEND, 8'h80);
    send_item(OP_APPEND, 8'h7f);
    send_item(OP_FINISH, 8'ha5);
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    hold_req = ~hold_req;
    send_random_bytes(5);
    send_item(OP_FINISH, 8'($urandom));
    send_random_bytes(6);
    send_item(OP_FINISH, 8'($urandom));
  endtask

  // Sender pauses until every digest word is out, then goes on
  task automatic test_sender_pause();
    send_random_bytes(3);
    send_item(OP_FINISH, 8'($urandom));
    wait_digests_drained();
    send_random_bytes(2);
    send_item(OP_FINISH, 8'($urandom));
  endtask

  // Whole messages with random content; lengths lean on block edges
  task automatic test_random_messages(int unsigned n_items, bit first_edges);
    int unsigned edge_len [4] = '{55, 56, 63, 64};
    int unsigned pick_len [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
    int unsigned stop_at;
    int unsigned msg_no;
    int unsigned len;
    stop_at = items_sent + n_items;
    msg_no = 0;
    while (items_sent < stop_at) begin
      if (first_edges && msg_no < 4) len = edge_len[msg_no];
      else if ($urandom_range(0, 3) == 0) len = pick_len[$urandom_range(0, 9)];
      else len = $urandom_range(1, 40);
      send_random_bytes(len);
      send_item(OP_FINISH, 8'($urandom));
      msg_no++;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = OP_APPEND;
    data_byte_i = 8'h00;
    out_ready_i = 1'b0;
    hash_restart();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_sender_pause();
    test_random_messages(320, 1'b1);
    quiet = 1'b1;
    test_random_messages(90, 1'b0);

    wait_digests_drained();
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
